// ===== rtl/flcl_pkg.sv =====
// flcl_pkg: shared types and constants for the FLAC cover locator.
// No dependencies; imported by flcl_parser, flcl_out_buf and the top level.
package flcl_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned WordW   = 32;
    localparam int unsigned StatusW = 3;
    localparam int unsigned LenW    = 24;
    localparam int unsigned ResultW = 72;

    localparam logic [StatusW-1:0] ST_FOUND      = 3'd0;
    localparam logic [StatusW-1:0] ST_NOT_FLAC   = 3'd1;
    localparam logic [StatusW-1:0] ST_NO_MATCH   = 3'd2;
    localparam logic [StatusW-1:0] ST_TRUNCATED  = 3'd3;
    localparam logic [StatusW-1:0] ST_EMPTY_PIC  = 3'd4;

    localparam logic [WordW-1:0] MAGIC_WORD      = 32'h664C_6143;
    localparam logic [6:0]       TYPE_PICTURE    = 7'd6;
    localparam logic [2:0]       DIM_WORDS       = 3'd4;
    localparam logic [WordW-1:0] WANTED_RESET    = 32'd3;

    typedef struct packed {
        logic [WordW-1:0]   size;
        logic [WordW-1:0]   offset;
        logic [StatusW-1:0] status;
    } flcl_result_t;

endpackage

// ===== rtl/flac_cover_locator_unit.sv =====
// flac_cover_locator_unit: top level of the FLAC cover picture locator.
// Depends on flcl_pkg, flcl_parser and flcl_out_buf.
//
//  channel  dir  signals                       item
//  s_*      in   s_tvalid s_tready s_tdata     stream_byte, tlast = stream_end
//                s_tlast
//  m_*      out  m_tvalid m_tready m_tdata     status, cover_offset, cover_size
//  cfg_*    in   cfg_we cfg_wdata              wanted_picture_type
//
// One byte is taken per cycle while s_tready is high; its result, if any, is in the
// result register the next cycle when that register is free, else in the skid entry.
// The result register plus one skid entry decouple the two sides, so s_tready drops
// only while both hold an unread result. Reset clears the parser state and sets
// wanted_picture_type to 3 (front cover).
module flac_cover_locator_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] stream_byte
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [flcl_pkg::ResultW-1:0] m_tdata,   // [2:0] status, [34:3] cover_offset,
                                                    // [66:35] cover_size, [71:67] zero
    input  logic                         cfg_we,
    input  logic [flcl_pkg::WordW-1:0]   cfg_wdata
);
    import flcl_pkg::*;

    logic [WordW-1:0] wanted_reg;
    logic             accept;
    logic             emit;
    flcl_result_t     result;
    flcl_result_t     out_data;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wanted_reg <= WANTED_RESET;
        else if (cfg_we)
            wanted_reg <= cfg_wdata;
    end

    flcl_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (s_tdata),
        .in_end      (s_tlast),
        .wanted_type (wanted_reg),
        .emit        (emit),
        .result      (result)
    );

    flcl_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (emit),
        .in_data   (result),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_ready (m_tready)
    );

    assign m_tdata = {(ResultW - $bits(flcl_result_t))'(0), out_data};

endmodule

// ===== rtl/flcl_parser.sv =====
// flcl_parser: byte-wise walk of the FLAC magic and metadata blocks.
// Depends on flcl_pkg. One item per cycle while accept is high; emits at most one result per stream.
module flcl_parser
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [flcl_pkg::ByteW-1:0] in_byte,
    input  logic                      in_end,
    input  logic [flcl_pkg::WordW-1:0] wanted_type,
    output logic                      emit,
    output flcl_pkg::flcl_result_t    result
);
    import flcl_pkg::*;

    typedef enum logic [3:0] {
        PH_MAGIC,
        PH_HEADER,
        PH_SKIP,
        PH_PTYPE,
        PH_MIMELEN,
        PH_MIMESKIP,
        PH_DESCLEN,
        PH_DESCSKIP,
        PH_DIMS,
        PH_DATALEN
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [WordW-1:0] pos_reg, pos_next;
    logic [WordW-1:0] shift_reg, shift_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [LenW-1:0]  skip_reg, skip_next;
    logic [LenW-1:0]  blk_reg, blk_next;
    logic             last_reg, last_next;
    logic             answered_reg, answered_next;
    logic [2:0]       dims_reg, dims_next;

    logic [WordW-1:0]   word;
    logic [LenW-1:0]    blk_dec;
    logic [2:0]         dims_dec;
    logic               give;
    logic [StatusW-1:0] give_status;
    logic [WordW-1:0]   give_off;
    logic [WordW-1:0]   give_sz;
    logic               bs_req;
    logic [LenW-1:0]    bs_n;
    logic               sd_req;
    logic               bw_req;
    phase_t             bw_phase;
    logic [LenW-1:0]    bw_blk;
    logic               bstr_req;
    phase_t             bstr_skip_ph;
    phase_t             bstr_next_ph;

    assign word     = {shift_reg[LenW-1:0], in_byte};
    assign blk_dec  = blk_reg - LenW'(1);
    assign dims_dec = dims_reg - 3'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        shift_next    = shift_reg;
        cnt_next      = cnt_reg;
        skip_next     = skip_reg;
        blk_next      = blk_reg;
        last_next     = last_reg;
        answered_next = answered_reg;
        dims_next     = dims_reg;
        give          = 1'b0;
        give_status   = ST_FOUND;
        give_off      = '0;
        give_sz       = '0;
        bs_req        = 1'b0;
        bs_n          = '0;
        sd_req        = 1'b0;
        bw_req        = 1'b0;
        bw_phase      = PH_HEADER;
        bw_blk        = blk_reg;
        bstr_req      = 1'b0;
        bstr_skip_ph  = PH_MIMESKIP;
        bstr_next_ph  = PH_DESCLEN;

        if (accept && !answered_reg)
        begin
            case (phase_reg)
                PH_MAGIC, PH_HEADER:
                begin
                    shift_next = word;
                    cnt_next   = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        if (phase_reg == PH_MAGIC)
                        begin
                            if (word == MAGIC_WORD)
                            begin
                                phase_next = PH_HEADER;
                                shift_next = '0;
                                cnt_next   = '0;
                            end
                            else
                            begin
                                give        = 1'b1;
                                give_status = ST_NOT_FLAC;
                            end
                        end
                        else
                        begin
                            last_next = word[31];
                            if (word[30:24] != TYPE_PICTURE)
                            begin
                                bs_req = 1'b1;
                                bs_n   = word[LenW-1:0];
                            end
                            else
                            begin
                                blk_next = word[LenW-1:0];
                                bw_req   = 1'b1;
                                bw_phase = PH_PTYPE;
                                bw_blk   = word[LenW-1:0];
                            end
                        end
                    end
                end
                PH_SKIP, PH_MIMESKIP, PH_DESCSKIP:
                begin
                    skip_next = skip_reg - LenW'(1);
                    if (skip_reg == LenW'(1))
                    begin
                        if (phase_reg == PH_SKIP)
                            sd_req = 1'b1;
                        else
                        begin
                            bw_req   = 1'b1;
                            bw_phase = (phase_reg == PH_MIMESKIP) ? PH_DESCLEN : PH_DIMS;
                            bw_blk   = blk_reg;
                        end
                    end
                end
                default:
                begin
                    shift_next = word;
                    cnt_next   = cnt_reg + 2'd1;
                    blk_next   = blk_dec;
                    if (cnt_reg == 2'd3)
                    begin
                        case (phase_reg)
                            PH_PTYPE:
                            begin
                                if (word != wanted_type)
                                begin
                                    bs_req = 1'b1;
                                    bs_n   = blk_dec;
                                end
                                else
                                begin
                                    bw_req   = 1'b1;
                                    bw_phase = PH_MIMELEN;
                                    bw_blk   = blk_dec;
                                end
                            end
                            PH_MIMELEN:
                            begin
                                bstr_req     = 1'b1;
                                bstr_skip_ph = PH_MIMESKIP;
                                bstr_next_ph = PH_DESCLEN;
                            end
                            PH_DESCLEN:
                            begin
                                dims_next    = DIM_WORDS;
                                bstr_req     = 1'b1;
                                bstr_skip_ph = PH_DESCSKIP;
                                bstr_next_ph = PH_DIMS;
                            end
                            PH_DIMS:
                            begin
                                dims_next = dims_dec;
                                bw_req    = 1'b1;
                                bw_phase  = (dims_dec != 3'd0) ? PH_DIMS : PH_DATALEN;
                                bw_blk    = blk_dec;
                            end
                            default:
                            begin
                                give     = 1'b1;
                                give_off = pos_reg + WordW'(1);
                                if (word == '0)
                                    give_status = ST_EMPTY_PIC;
                                else
                                begin
                                    give_status = ST_FOUND;
                                    give_sz     = word;
                                end
                            end
                        endcase
                    end
                end
            endcase

            // string length: overrun, empty, or skip it
            if (bstr_req)
            begin
                if (word > {{(WordW-LenW){1'b0}}, blk_dec})
                begin
                    give        = 1'b1;
                    give_status = ST_NO_MATCH;
                end
                else if (word == '0)
                begin
                    bw_req   = 1'b1;
                    bw_phase = bstr_next_ph;
                    bw_blk   = blk_dec;
                end
                else
                begin
                    skip_next  = word[LenW-1:0];
                    blk_next   = blk_dec - word[LenW-1:0];
                    phase_next = bstr_skip_ph;
                end
            end

            if (bs_req)
            begin
                skip_next = bs_n;
                if (bs_n == '0)
                    sd_req = 1'b1;
                else
                    phase_next = PH_SKIP;
            end

            if (sd_req)
            begin
                if (last_next)
                begin
                    give        = 1'b1;
                    give_status = ST_NO_MATCH;
                end
                else
                begin
                    phase_next = PH_HEADER;
                    shift_next = '0;
                    cnt_next   = '0;
                end
            end

            if (bw_req)
            begin
                if (bw_blk < LenW'(4))
                begin
                    give        = 1'b1;
                    give_status = ST_NO_MATCH;
                end
                else
                begin
                    phase_next = bw_phase;
                    shift_next = '0;
                    cnt_next   = '0;
                end
            end
        end

        if (accept && in_end && !answered_reg && !give)
        begin
            give        = 1'b1;
            give_status = ST_TRUNCATED;
            give_off    = '0;
            give_sz     = '0;
        end

        if (give)
            answered_next = 1'b1;

        if (accept)
        begin
            pos_next = pos_reg + WordW'(1);
            if (in_end)
            begin
                phase_next    = PH_MAGIC;
                pos_next      = '0;
                shift_next    = '0;
                cnt_next      = '0;
                skip_next     = '0;
                blk_next      = '0;
                last_next     = 1'b0;
                answered_next = 1'b0;
                dims_next     = '0;
            end
        end
    end

    assign emit          = give;
    assign result.status = give_status;
    assign result.offset = give_off;
    assign result.size   = give_sz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MAGIC;
            pos_reg      <= '0;
            shift_reg    <= '0;
            cnt_reg      <= '0;
            skip_reg     <= '0;
            blk_reg      <= '0;
            last_reg     <= 1'b0;
            answered_reg <= 1'b0;
            dims_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            shift_reg    <= shift_next;
            cnt_reg      <= cnt_next;
            skip_reg     <= skip_next;
            blk_reg      <= blk_next;
            last_reg     <= last_next;
            answered_reg <= answered_next;
            dims_reg     <= dims_next;
        end
    end

`ifndef SYNTHESIS
    a_emit_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> accept)
        else $error("result without an accepted item");

    a_once_per_stream: assert property (@(posedge clk) disable iff (!rst_n)
        answered_reg |-> !emit)
        else $error("second result in one stream");

    a_end_answers: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_end && !answered_reg |-> emit)
        else $error("stream ended without a result");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_end |=> pos_reg == '0 && !answered_reg && phase_reg == PH_MAGIC)
        else $error("state not cleared after final byte");
`endif

endmodule

// ===== rtl/flcl_out_buf.sv =====
// flcl_out_buf: result register with one skid entry behind it.
// Depends on flcl_pkg. Keeps the upstream ready free of the downstream ready.
module flcl_out_buf
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  flcl_pkg::flcl_result_t in_data,
    output logic                   in_ready,
    output logic                   out_valid,
    output flcl_pkg::flcl_result_t out_data,
    input  logic                   out_ready
);
    import flcl_pkg::*;

    logic         out_valid_reg;
    flcl_result_t out_data_reg;
    logic         skid_valid_reg;
    flcl_result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        else if (in_valid && !skid_valid_reg)
            skid_data_reg <= in_data;
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty result register");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready && in_valid))
        else $error("skid entry filled without a stall");
`endif

endmodule

// ===== verif/flac_cover_locator_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for flac_cover_locator_unit: byte streams in, locator answers out.
// Depends on flcl_pkg and the RTL of flac_cover_locator_unit; carries its own answer predictor.
module flac_cover_locator_unit_test;

    import flcl_pkg::*;

    localparam int SETTLE_CYCLES  = 4;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [3:0]
    {
        WALK_MAGIC,
        WALK_HEADER,
        WALK_SKIP,
        WALK_PTYPE,
        WALK_MIME_LEN,
        WALK_MIME_SKIP,
        WALK_DESC_LEN,
        WALK_DESC_SKIP,
        WALK_DIMS,
        WALK_DATA_LEN
    } walk_e;

    typedef struct packed
    {
        logic [7:0] data;
        logic       last;
    } stream_item_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;   // [7:0] stream_byte
    logic                 s_tlast   = 1'b0;    // stream_end
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [ResultW-1:0]   m_tdata;             // [2:0] status, [34:3] offset, [66:35] size
    logic                 cfg_we    = 1'b0;
    logic [WordW-1:0]     cfg_wdata = '0;

    stream_item_t   pending_items[$];
    logic [7:0]     frame_q[$];
    flcl_result_t   cover_answers_q[$];

    int             queued_total = 0;
    int             tx_idle_pct  = 0;
    int             rx_idle_pct  = 0;
    int             fault_count  = 0;
    logic           s_took       = 1'b0;
    logic           hold_go      = 1'b0;
    logic           rx_hold      = 1'b0;
    logic [31:0]    cur_wanted   = WANTED_RESET;

    // predictor state
    logic [31:0]    wanted_type = WANTED_RESET;
    walk_e          walk        = WALK_MAGIC;
    logic [31:0]    byte_pos    = '0;
    logic [31:0]    shift_reg   = '0;
    int             shift_cnt   = 0;
    logic [31:0]    skip_left   = '0;
    logic [31:0]    block_left  = '0;
    logic           last_flag   = 1'b0;
    logic           answered    = 1'b0;
    logic [2:0]     dims_left   = '0;
    flcl_result_t   answer      = '0;

    flac_cover_locator_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic void post_answer(logic [2:0] st, logic [31:0] off, logic [31:0] sz);
        answered      = 1'b1;
        answer.status = st;
        answer.offset = off;
        answer.size   = sz;
    endfunction

    function automatic void open_field(walk_e ph);
        walk      = ph;
        shift_reg = '0;
        shift_cnt = 0;
    endfunction

    function automatic void open_word(walk_e ph);
        if (block_left < 4)
            post_answer(ST_NO_MATCH, '0, '0);
        else
            open_field(ph);
    endfunction

    function automatic void close_skip();
        if (last_flag)
            post_answer(ST_NO_MATCH, '0, '0);
        else
            open_field(WALK_HEADER);
    endfunction

    function automatic void start_block_skip(logic [31:0] n);
        skip_left = n;
        if (n == 0)
            close_skip();
        else
            walk = WALK_SKIP;
    endfunction

    function automatic void start_string(logic [31:0] n, walk_e skip_ph, walk_e next_ph);
        if (n > block_left)
            post_answer(ST_NO_MATCH, '0, '0);
        else if (n == 0)
            open_word(next_ph);
        else
        begin
            skip_left  = n;
            block_left = block_left - n;
            walk       = skip_ph;
        end
    endfunction

    // advances the walk by one byte; returns 1 when this byte yields an answer
    function automatic logic locate_step(logic [7:0] b, logic eos);
        walk_e ph;
        logic  emit;
        ph   = walk;
        emit = 1'b0;
        if (!answered)
        begin
            case (ph)
                WALK_MAGIC, WALK_HEADER:
                begin
                    shift_reg = {shift_reg[23:0], b};
                    shift_cnt++;
                    if (shift_cnt >= 4)
                    begin
                        if (ph == WALK_MAGIC)
                        begin
                            if (shift_reg == MAGIC_WORD)
                                open_field(WALK_HEADER);
                            else
                                post_answer(ST_NOT_FLAC, '0, '0);
                        end
                        else
                        begin
                            last_flag = shift_reg[31];
                            if (shift_reg[30:24] != TYPE_PICTURE)
                                start_block_skip({8'd0, shift_reg[23:0]});
                            else
                            begin
                                block_left = {8'd0, shift_reg[23:0]};
                                open_word(WALK_PTYPE);
                            end
                        end
                    end
                end
                WALK_SKIP, WALK_MIME_SKIP, WALK_DESC_SKIP:
                begin
                    skip_left = skip_left - 1;
                    if (skip_left == 0)
                    begin
                        if (ph == WALK_SKIP)
                            close_skip();
                        else if (ph == WALK_MIME_SKIP)
                            open_word(WALK_DESC_LEN);
                        else
                            open_word(WALK_DIMS);
                    end
                end
                default:
                begin
                    shift_reg  = {shift_reg[23:0], b};
                    shift_cnt++;
                    block_left = block_left - 1;
                    if (shift_cnt >= 4)
                    begin
                        case (ph)
                            WALK_PTYPE:
                                if (shift_reg != wanted_type)
                                    start_block_skip(block_left);
                                else
                                    open_word(WALK_MIME_LEN);
                            WALK_MIME_LEN:
                                start_string(shift_reg, WALK_MIME_SKIP, WALK_DESC_LEN);
                            WALK_DESC_LEN:
                            begin
                                dims_left = DIM_WORDS;
                                start_string(shift_reg, WALK_DESC_SKIP, WALK_DIMS);
                            end
                            WALK_DIMS:
                            begin
                                dims_left = dims_left - 3'd1;
                                open_word(dims_left != 0 ? WALK_DIMS : WALK_DATA_LEN);
                            end
                            default:
                                if (shift_reg == 0)
                                    post_answer(ST_EMPTY_PIC, byte_pos + 32'd1, '0);
                                else
                                    post_answer(ST_FOUND, byte_pos + 32'd1, shift_reg);
                        endcase
                    end
                end
            endcase
            emit = answered;
        end
        if (eos && !answered)
        begin
            post_answer(ST_TRUNCATED, '0, '0);
            emit = 1'b1;
        end
        byte_pos = byte_pos + 32'd1;
        if (eos)
        begin
            walk       = WALK_MAGIC;
            byte_pos   = '0;
            shift_reg  = '0;
            shift_cnt  = 0;
            skip_left  = '0;
            block_left = '0;
            last_flag  = 1'b0;
            answered   = 1'b0;
            dims_left  = '0;
        end
        return emit;
    endfunction

    function automatic void report_fault(string what, logic [71:0] want, logic [71:0] got);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("ERROR %0s: expected %0h, got %0h", what, want, got);
    endfunction

    always @(posedge clk)
    begin
        s_took = rst_n && s_tvalid && s_tready;
        if (rst_n && cfg_we)
            wanted_type = cfg_wdata;
        if (s_took && locate_step(s_tdata, s_tlast))
            cover_answers_q.push_back(answer);
    end

    always @(posedge clk)
    begin : result_check
        flcl_result_t want;
        flcl_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(flcl_result_t)-1:0];
            if (cover_answers_q.size() == 0)
                report_fault("answer with none pending", '0, m_tdata);
            else
            begin
                want = cover_answers_q.pop_front();
                if (got.status != want.status)
                    report_fault("status", 72'(want.status), 72'(got.status));
                if (got.offset != want.offset)
                    report_fault("cover_offset", 72'(want.offset), 72'(got.offset));
                if (got.size != want.size)
                    report_fault("cover_size", 72'(want.size), 72'(got.size));
                if (m_tdata[ResultW-1:$bits(flcl_result_t)] != 0)
                    report_fault("padding", '0,
                                 72'(m_tdata[ResultW-1:$bits(flcl_result_t)]));
            end
        end
    end

    always @(negedge clk)
    begin : feed
        stream_item_t it;
        if (rst_n && (!s_tvalid || s_took))
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it.data;
                s_tlast  <= it.last;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
        m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);

    // long receiver stall so the result register and skid entry fill
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    task automatic add_word(logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            frame_q.push_back(w[8*i +: 8]);
    endtask

    task automatic add_noise(int n);
        logic [7:0] b;
        repeat (n)
        begin
            b = 8'($urandom_range(0, 255));
            frame_q.push_back(b);
        end
    endtask

    task automatic commit_frame();
        stream_item_t it;
        foreach (frame_q[i])
        begin
            it.data = frame_q[i];
            it.last = (i == frame_q.size() - 1);
            pending_items.push_back(it);
        end
        queued_total += frame_q.size();
        frame_q.delete();
    endtask

    task automatic drain_results();
        while (pending_items.size() != 0 || s_tvalid)
            @(posedge clk);
        while (cover_answers_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_wanted(logic [31:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_wanted = v;
    endtask

    task automatic run_random_phase(int target, int tx_pct, int rx_pct);
        int          start;
        int          kind;
        int          n_blocks;
        int          mime_n;
        int          desc_n;
        int          data_n;
        int          pic_len;
        int          blk_len;
        int          cut;
        logic [31:0] w;
        logic [31:0] ptype;
        logic [31:0] dlen;
        logic        lastf;
        logic [6:0]  btype;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start       = queued_total;
        while (queued_total - start < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 6)
                add_noise($urandom_range(1, 6));
            else
            begin
                w = MAGIC_WORD;
                if (kind < 10)
                    w[7:0] = 8'($urandom_range(0, 255));
                add_word(w);
                n_blocks = $urandom_range(0, 4);
                for (int i = 0; i < n_blocks; i++)
                begin
                    lastf = (i == n_blocks - 1) && ($urandom_range(0, 9) != 0);
                    if ($urandom_range(0, 1) == 0)
                    begin
                        btype     = 7'($urandom_range(0, 127));
                        blk_len   = $urandom_range(0, 12);
                        w         = blk_len;
                        w[31]     = lastf;
                        w[30:24]  = btype;
                        add_word(w);
                        add_noise(blk_len);
                    end
                    else
                    begin
                        mime_n  = $urandom_range(0, 6);
                        desc_n  = $urandom_range(0, 6);
                        data_n  = $urandom_range(0, 4);
                        pic_len = 32 + mime_n + desc_n + data_n;
                        if ($urandom_range(0, 9) < 8)
                            blk_len = pic_len;
                        else
                            blk_len = $urandom_range(0, pic_len);
                        w        = blk_len;
                        w[31]    = lastf;
                        w[30:24] = TYPE_PICTURE;
                        add_word(w);
                        case ($urandom_range(0, 3))
                            0:       ptype = $urandom;
                            1:       ptype = cur_wanted ^ (32'd1 << $urandom_range(0, 31));
                            default: ptype = cur_wanted;
                        endcase
                        add_word(ptype);
                        if ($urandom_range(0, 19) == 0)
                            w = $urandom;
                        else
                            w = mime_n;
                        add_word(w);
                        add_noise(mime_n);
                        add_word(desc_n);
                        add_noise(desc_n);
                        repeat (4) add_word($urandom);
                        case ($urandom_range(0, 3))
                            0:       dlen = '0;
                            1:       dlen = data_n;
                            2:       dlen = $urandom;
                            default: dlen = 32'hFFFF_FFFF;
                        endcase
                        add_word(dlen);
                        add_noise(data_n);
                    end
                end
            end
            if ($urandom_range(0, 9) == 0 && frame_q.size() > 1)
            begin
                cut = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > cut)
                    frame_q.delete(frame_q.size() - 1);
            end
            commit_frame();
        end
        drain_results();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // bad magic, one-byte file, empty last block, empty non-last block at end of file
        add_word(32'h00FF_00FF);
        commit_frame();
        frame_q.push_back(MAGIC_WORD[31:24]);
        commit_frame();
        add_word(MAGIC_WORD);
        add_word(32'hFF00_0000);
        commit_frame();
        add_word(MAGIC_WORD);
        add_word(32'h7F00_0000);
        commit_frame();
        drain_results();

        hold_go = 1'b1;
        repeat (20)
        begin
            add_noise(4);
            commit_frame();
        end
        drain_results();

        write_wanted(32'd0);
        run_random_phase(560, 28, 78);
        write_wanted(32'hFFFF_FFFF);
        run_random_phase(560, 78, 28);
        write_wanted($urandom_range(0, 20));
        run_random_phase(560, 0, 0);

        repeat (10) @(posedge clk);
        if (fault_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== flac_cover_locator_unit.f =====
rtl/flcl_pkg.sv
rtl/flcl_parser.sv
rtl/flcl_out_buf.sv
rtl/flac_cover_locator_unit.sv
verif/flac_cover_locator_unit_test.sv
